// ----- rtl/bcc_pkg.sv -----
`timescale 1ns / 1ps

package bcc_pkg;

    localparam int unsigned MAX_N_DEF = 64;
    localparam int unsigned IN_W      = 7;
    localparam int unsigned COEF_W    = 61;

    // per-cycle commands broadcast along the cell chain
    typedef struct packed {
        logic clear;  // start of a request: row 0 (all cells zero)
        logic step;   // advance one Pascal row
    } cell_ctrl_t;

endpackage

// ----- rtl/bcc_cell.sv -----
`timescale 1ns / 1ps

// One column of the Pascal row: holds row[j], adds row[j-1] from the left neighbor.
module bcc_cell (
    input  logic                             aclk,
    input  bcc_pkg::cell_ctrl_t              ctrl,
    input  logic [bcc_pkg::COEF_W-1:0]       left_val,
    output logic [bcc_pkg::COEF_W-1:0]       val
);

    logic [bcc_pkg::COEF_W-1:0] val_reg;
    logic [bcc_pkg::COEF_W-1:0] val_next;

    // all cells update together, so each sees the previous row: same as the
    // in-place descending sweep; the sum wraps mod 2^COEF_W
    always_comb begin
        val_next = val_reg;
        if (ctrl.clear) begin
            val_next = '0;
        end else if (ctrl.step) begin
            val_next = val_reg + left_val;
        end
    end

    always_ff @(posedge aclk) begin
        val_reg <= val_next;
    end

    assign val = val_reg;

endmodule

// ----- rtl/binomial_coefficient_core.sv -----
`timescale 1ns / 1ps

// Binomial coefficient engine: C(n, r) by Pascal rows on a chain of adder cells.
//
// Input channel (s_valid/s_ready): one word carries s_total (n) and s_chosen (r).
// Result channel (m_valid/m_ready): one word carries m_coefficient = C(n, r)
// (61 bits) and m_invalid. A request with r > n or n > MAX_N gives
// m_invalid = 1 and m_coefficient = 0.
//
// r is folded to min(r, n - r), so MAX_N/2 cells hold row entries 1..MAX_N/2;
// entry 0 is the constant 1 feeding the first cell. Each cycle the whole row
// advances by one, so a request walks n rows.
//
// One request at a time: an accepted request walks n rows through the cell
// chain, and a rejected one skips the walk. s_ready returns as soon as the
// result lands in the output register, so a new word is taken while the
// previous result still waits; if the receiver stalls, a finished result
// waits in the engine until the output register frees up.
//
// Reset (aresetn low, synchronous): engine idle, output register empty.
module binomial_coefficient_core #(
    parameter int unsigned MAX_N = bcc_pkg::MAX_N_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [bcc_pkg::IN_W-1:0]         s_total,
    input  logic [bcc_pkg::IN_W-1:0]         s_chosen,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [bcc_pkg::COEF_W-1:0]       m_coefficient,
    output logic                             m_invalid
);

    localparam int unsigned NCELL = (MAX_N / 2 > 0) ? MAX_N / 2 : 1;
    localparam int unsigned SEL_W = $clog2(NCELL + 1);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t                        state_reg;
    logic [bcc_pkg::IN_W-1:0]      count_reg;   // rows still to walk
    logic [SEL_W-1:0]              sel_reg;     // folded r
    logic                          inv_reg;
    logic                          m_valid_reg;
    logic [bcc_pkg::COEF_W-1:0]    m_coef_reg;
    logic                          m_inv_reg;

    logic                          s_fire;
    logic                          out_free;
    logic                          finish;
    logic                          bad_req;
    logic [bcc_pkg::IN_W-1:0]      diff;
    logic [bcc_pkg::IN_W-1:0]      fold;
    logic [bcc_pkg::COEF_W-1:0]    pick;
    bcc_pkg::cell_ctrl_t           ctrl;
    logic [bcc_pkg::COEF_W-1:0]    vals [NCELL];

    // no word is taken while reset is held
    assign s_ready  = aresetn && (state_reg == ST_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign finish   = (state_reg == ST_RUN) && (count_reg == '0) && out_free;

    assign bad_req = (s_chosen > s_total) || (s_total > bcc_pkg::IN_W'(MAX_N));
    assign diff    = s_total - s_chosen;
    assign fold    = (diff < s_chosen) ? diff : s_chosen;

    assign ctrl.clear = s_fire;
    assign ctrl.step  = (state_reg == ST_RUN) && (count_reg != '0);

    // cell k holds row entry k+1; entry 0 is always 1
    for (genvar k = 0; k < NCELL; k++) begin : g_cell
        bcc_cell u_cell (
            .aclk     (aclk),
            .ctrl     (ctrl),
            .left_val ((k == 0) ? bcc_pkg::COEF_W'(1) : vals[(k == 0) ? 0 : k - 1]),
            .val      (vals[k])
        );
    end

    // pick entry r of the final row
    always_comb begin
        pick = bcc_pkg::COEF_W'(1);
        for (int k = 0; k < NCELL; k++) begin
            if (sel_reg == SEL_W'(k + 1)) begin
                pick = vals[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            // a finishing result reloads the output register in the same cycle
            if (m_valid_reg && m_ready && !finish) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        // rejected requests skip the row walk
                        count_reg <= bad_req ? '0 : s_total;
                        sel_reg   <= bad_req ? '0 : SEL_W'(fold);
                        inv_reg   <= bad_req;
                        state_reg <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    if (count_reg != '0) begin
                        count_reg <= count_reg - 1'b1;
                    end else if (finish) begin
                        m_valid_reg <= 1'b1;
                        m_coef_reg  <= inv_reg ? '0 : pick;
                        m_inv_reg   <= inv_reg;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_coefficient = m_coef_reg;
    assign m_invalid     = m_inv_reg;

endmodule

// ----- rtl/bcc_checker.sv -----
`timescale 1ns / 1ps

module bcc_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_valid,
    input logic                             s_ready,
    input logic                             m_valid,
    input logic                             m_ready,
    input logic [bcc_pkg::COEF_W-1:0]       m_coefficient,
    input logic                             m_invalid
);

    // one request in flight: busy right after a word is taken
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while engine busy");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_coefficient) && $stable(m_invalid))
        else $error("stalled result changed");

    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_invalid |-> m_coefficient == '0)
        else $error("rejected request with nonzero coefficient");

    // a valid binomial coefficient is never zero
    a_valid_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_invalid |-> m_coefficient != '0)
        else $error("zero coefficient on accepted request");

endmodule

bind binomial_coefficient_core bcc_checker u_bcc_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_coefficient (m_coefficient),
    .m_invalid     (m_invalid)
);
